/* design/dthm_pkg.sv */
// Package for the two-source HTP DMX merge core.
// Holds field widths, operation codes and the payload and control struct types.
// No dependencies.
`default_nettype none

package dthm_pkg;

    localparam int IP_W               = 32;
    localparam int CNT_W              = 10;
    localparam int IDX_W              = 9;
    localparam int LVL_W              = 8;
    localparam int UNIVERSE_SLOTS_DEF = 512;

    typedef enum logic [1:0] {
        OP_DATA   = 2'd0,
        OP_CANCEL = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef struct packed {
        t_op               operation;
        logic [IP_W-1:0]   sender_ip;
        logic [CNT_W-1:0]  packet_slots;
        logic [IDX_W-1:0]  slot_index;
        logic [LVL_W-1:0]  slot_value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]  out_index;
        logic [LVL_W-1:0]  merged_value;
        logic [CNT_W-1:0]  merged_slots;
        logic              accepted;
    } t_out_item;

    // Per-item decision from the source tracker to the merge stage
    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic              accepted;
        logic              live_a;
        logic              live_b;
        logic [CNT_W-1:0]  merged_slots;
    } t_src_ctl;

endpackage

`default_nettype wire

/* design/dmx_two_source_htp_merge_core.sv */
// Input, store-access and output registers; one item per cycle unless output stalls.
// Each item does one read and at most one write in a single-port level store per
// source, in the same cycle; the stores are what fix the rate at one item per cycle.
// Reset clears source addresses, counts, extents and pipeline valids at once.
// The level stores are not cleared; an empty extent hides their contents.
// Top level of the two-source HTP merge. Uses dthm_pkg, dthm_source_ctrl,
// dthm_level_ram and dthm_merge_out.
`default_nettype none

module dmx_two_source_htp_merge_core #(
    parameter int UNIVERSE_SLOTS = dthm_pkg::UNIVERSE_SLOTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire dthm_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output dthm_pkg::t_out_item      o_out_data
);

    import dthm_pkg::*;

    localparam int ADDR_W = (UNIVERSE_SLOTS > 1) ? $clog2(UNIVERSE_SLOTS) : 1;

    logic             r_s1_valid;
    t_in_item         r_s1_data;
    logic             r_s2_valid;
    t_src_ctl         r_s2_ctl;
    logic [IDX_W-1:0] r_s2_idx;
    logic [LVL_W-1:0] r_s2_value;

    t_src_ctl         ctl;
    logic             take;
    logic             en_s2;
    logic             en_s1;
    logic             step;
    logic [LVL_W-1:0] rd_a, rd_b;

    assign en_s2      = !r_s2_valid || take;
    assign en_s1      = !r_s1_valid || en_s2;
    assign step       = r_s1_valid && en_s2;
    assign o_in_ready = en_s1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en_s1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1 && i_in_valid) begin
            r_s1_data <= i_in_data;
        end
    end

    dthm_source_ctrl #(
        .UNIVERSE_SLOTS (UNIVERSE_SLOTS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_s1_data),
        .o_ctl   (ctl)
    );

    dthm_level_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (LVL_W)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_en    (step),
        .i_we    (ctl.wr_a),
        .i_addr  (r_s1_data.slot_index[ADDR_W-1:0]),
        .i_wdata (r_s1_data.slot_value),
        .o_rdata (rd_a)
    );

    dthm_level_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (LVL_W)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_en    (step),
        .i_we    (ctl.wr_b),
        .i_addr  (r_s1_data.slot_index[ADDR_W-1:0]),
        .i_wdata (r_s1_data.slot_value),
        .o_rdata (rd_b)
    );

    // store-access stage, beside the registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en_s2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_s2_ctl   <= ctl;
            r_s2_idx   <= r_s1_data.slot_index;
            r_s2_value <= r_s1_data.slot_value;
        end
    end

    dthm_merge_out u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s2_valid),
        .o_take      (take),
        .i_ctl       (r_s2_ctl),
        .i_index     (r_s2_idx),
        .i_value     (r_s2_value),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked while the result register is empty");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !en_s2 |=> r_s1_valid && $stable(r_s1_data))
        else $error("input stage item lost while stalled");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !take |=> r_s2_valid && $stable(r_s2_idx) && $stable(rd_a)
            && $stable(rd_b))
        else $error("store stage item or read data changed while stalled");

endmodule

`default_nettype wire

/* design/dthm_level_ram.sv */
// Level store of one source: single-port RAM, read-first, registered read data.
// Depends on nothing.
`default_nettype none

module dthm_level_ram #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/dthm_source_ctrl.sv */
// Source tracker: sender addresses, slot counts, valid extents and merged count.
// Decides per item which store is written and which levels are live. Uses dthm_pkg.
`default_nettype none

module dthm_source_ctrl #(
    parameter int UNIVERSE_SLOTS = dthm_pkg::UNIVERSE_SLOTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire dthm_pkg::t_in_item i_item,
    output dthm_pkg::t_src_ctl     o_ctl
);

    import dthm_pkg::*;

    localparam logic [CNT_W-1:0] UNIV = CNT_W'(UNIVERSE_SLOTS);

    logic [IP_W-1:0]  r_a_addr, n_a_addr, r_b_addr, n_b_addr;
    logic [CNT_W-1:0] r_a_cnt, n_a_cnt, r_b_cnt, n_b_cnt;
    logic [CNT_W-1:0] r_a_ext, n_a_ext, r_b_ext, n_b_ext;
    logic [CNT_W-1:0] r_merged, n_merged;

    logic [CNT_W-1:0] slots_sat;
    logic [CNT_W-1:0] idx_ext;
    logic [CNT_W-1:0] idx_next;
    logic             in_range;
    logic             wr_a, wr_b, acc;

    // New extent of the written source, limited to its count
    function automatic logic [CNT_W-1:0] f_ext(
        input logic [CNT_W-1:0] ext,
        input logic             stored,
        input logic [CNT_W-1:0] idx,
        input logic [CNT_W-1:0] idx_p1,
        input logic [CNT_W-1:0] slots
    );
        logic [CNT_W-1:0] e;
        e = ext;
        if (stored) begin
            if (idx == '0) begin
                e = CNT_W'(1);
            end else if (idx_p1 > e) begin
                e = idx_p1;
            end
        end
        if (e > slots) begin
            e = slots;
        end
        return e;
    endfunction

    always_comb begin
        slots_sat = (i_item.packet_slots > UNIV) ? UNIV : i_item.packet_slots;
        idx_ext   = {1'b0, i_item.slot_index};
        idx_next  = idx_ext + CNT_W'(1);
        in_range  = idx_ext < slots_sat;

        n_a_addr = r_a_addr;
        n_b_addr = r_b_addr;
        n_a_cnt  = r_a_cnt;
        n_b_cnt  = r_b_cnt;
        n_a_ext  = r_a_ext;
        n_b_ext  = r_b_ext;
        n_merged = r_merged;
        wr_a     = 1'b0;
        wr_b     = 1'b0;
        acc      = 1'b0;

        case (i_item.operation)
            OP_DATA: begin
                if (i_item.sender_ip != '0) begin
                    // first sender claims A and drops B's levels
                    if (r_a_addr == '0) begin
                        n_a_addr = i_item.sender_ip;
                        n_b_ext  = '0;
                    end
                    if (i_item.sender_ip == n_a_addr) begin
                        acc     = 1'b1;
                        wr_a    = in_range;
                        n_a_cnt = slots_sat;
                        n_a_ext = f_ext(r_a_ext, in_range, idx_ext, idx_next, slots_sat);
                    end else begin
                        if (r_b_addr == '0) begin
                            n_b_addr = i_item.sender_ip;
                        end
                        if (i_item.sender_ip == n_b_addr) begin
                            acc     = 1'b1;
                            wr_b    = in_range;
                            n_b_cnt = slots_sat;
                            n_b_ext = f_ext(n_b_ext, in_range, idx_ext, idx_next, slots_sat);
                        end
                    end
                    if (acc) begin
                        n_merged = (n_a_cnt > n_b_cnt) ? n_a_cnt : n_b_cnt;
                    end
                end
            end
            OP_CANCEL: begin
                if (r_a_addr != i_item.sender_ip) begin
                    n_a_addr = '0;
                    n_a_ext  = '0;
                end
                if (r_b_addr != i_item.sender_ip) begin
                    n_b_addr = '0;
                    n_b_ext  = '0;
                end
            end
            OP_CLEAR: begin
                n_a_addr = '0;
                n_b_addr = '0;
                n_a_ext  = '0;
                n_b_ext  = '0;
                n_merged = UNIV;
            end
            OP_READ: begin
            end
            default: begin
            end
        endcase

        o_ctl.wr_a         = wr_a;
        o_ctl.wr_b         = wr_b;
        o_ctl.accepted     = acc;
        o_ctl.live_a       = idx_ext < n_a_ext;
        o_ctl.live_b       = idx_ext < n_b_ext;
        o_ctl.merged_slots = n_merged;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_addr <= '0;
            r_b_addr <= '0;
            r_a_cnt  <= '0;
            r_b_cnt  <= '0;
            r_a_ext  <= '0;
            r_b_ext  <= '0;
            r_merged <= '0;
        end else if (i_step) begin
            r_a_addr <= n_a_addr;
            r_b_addr <= n_b_addr;
            r_a_cnt  <= n_a_cnt;
            r_b_cnt  <= n_b_cnt;
            r_a_ext  <= n_a_ext;
            r_b_ext  <= n_b_ext;
            r_merged <= n_merged;
        end
    end

    a_one_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> $onehot0({wr_a, wr_b}))
        else $error("both level stores written by one transfer");

    a_ext_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_ext <= r_a_cnt && r_b_ext <= r_b_cnt)
        else $error("source extent beyond its slot count");

    a_unclaimed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_addr != '0 || r_a_ext == '0) && (r_b_addr != '0 || r_b_ext == '0))
        else $error("unclaimed source still has a live extent");

    a_merged_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_merged <= UNIV)
        else $error("merged slot count beyond universe size");

endmodule

`default_nettype wire

/* design/dthm_merge_out.sv */
// Merge stage: picks the live level of each source, takes the larger one
// and holds the result in the output register. Uses dthm_pkg.
`default_nettype none

module dthm_merge_out (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_take,
    input  wire dthm_pkg::t_src_ctl      i_ctl,
    input  wire logic [dthm_pkg::IDX_W-1:0] i_index,
    input  wire logic [dthm_pkg::LVL_W-1:0] i_value,
    input  wire logic [dthm_pkg::LVL_W-1:0] i_rd_a,
    input  wire logic [dthm_pkg::LVL_W-1:0] i_rd_b,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output dthm_pkg::t_out_item          o_out_data
);

    import dthm_pkg::*;

    logic             r_valid;
    t_out_item        r_data;
    logic [LVL_W-1:0] lvl_a, lvl_b;

    // store reads are read-first: use the byte this item wrote
    always_comb begin
        lvl_a = '0;
        lvl_b = '0;
        if (i_ctl.live_a) begin
            lvl_a = i_ctl.wr_a ? i_value : i_rd_a;
        end
        if (i_ctl.live_b) begin
            lvl_b = i_ctl.wr_b ? i_value : i_rd_b;
        end
    end

    assign o_take = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_data.out_index    <= i_index;
            r_data.merged_value <= (lvl_a > lvl_b) ? lvl_a : lvl_b;
            r_data.merged_slots <= i_ctl.merged_slots;
            r_data.accepted     <= i_ctl.accepted;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

`default_nettype wire

/* sim/dmx_two_source_htp_merge_core_tb.sv */
// Self-checking testbench for dmx_two_source_htp_merge_core: HTP merge of two DMX senders.
// Directed and random slot traffic is checked against an in-bench prediction of the merge.
// Depends on dthm_pkg and the core RTL only.
`default_nettype none

module dmx_two_source_htp_merge_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dthm_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int UNIVERSE     = UNIVERSE_SLOTS_DEF;
    localparam int TOTAL_ITEMS  = 1900;
    localparam int PHASE_ITEMS  = 300;
    localparam int IDLE_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 12;
    localparam int MAX_REPORTS  = 10;

    typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_BEAT} t_rx_mode;

    typedef struct packed {
        logic      hold;
        t_in_item  item;
        t_out_item want;
    } t_pend;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_item   i_in_data   = '0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_item  o_out_data;

    dmx_two_source_htp_merge_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predicted merge state, advanced in stimulus order
    logic [IP_W-1:0]  src_a_addr, src_b_addr;
    logic [CNT_W-1:0] src_a_cnt, src_b_cnt, src_a_ext, src_b_ext, merged_cnt;
    logic [LVL_W-1:0] levels_a [UNIVERSE];
    logic [LVL_W-1:0] levels_b [UNIVERSE];
    bit               written_a [UNIVERSE];
    bit               written_b [UNIVERSE];

    t_pend      pend_q[$];
    t_out_item  merge_expect_q[$];
    t_out_item  cur_want = '0;
    int         n_items = 0;
    int         n_bad = 0;
    int         idle_cycles = 0;
    int         burst_left = 1;
    int         gap_left = 0;
    logic [7:0] rx_cycle = '0;
    t_rx_mode   rx_mode = RX_OPEN;

    function automatic logic [CNT_W-1:0] grow_extent(input logic [CNT_W-1:0] ext,
                                                     input int idx,
                                                     input logic [CNT_W-1:0] slots);
        logic [CNT_W-1:0] e;
        e = ext;
        if (idx < slots) begin
            // slot 0 starts a new packet
            if (idx == 0) e = CNT_W'(1);
            else if (idx + 1 > ext) e = CNT_W'(idx + 1);
        end
        if (e > slots) e = slots;
        return e;
    endfunction

    // Merge result for one item; the state advances only when commit is set.
    // hole flags a result that would show a level never written.
    function automatic t_out_item htp_predict(input t_in_item it, input bit commit,
                                              output bit hole);
        logic [IP_W-1:0]  a_addr, b_addr, ip;
        logic [CNT_W-1:0] a_cnt, b_cnt, a_ext, b_ext, m_cnt, slots;
        logic [LVL_W-1:0] la, lb;
        bit               wa, wb, acc;
        int               idx;
        t_out_item        res;
        a_addr = src_a_addr;
        b_addr = src_b_addr;
        a_cnt  = src_a_cnt;
        b_cnt  = src_b_cnt;
        a_ext  = src_a_ext;
        b_ext  = src_b_ext;
        m_cnt  = merged_cnt;
        ip     = it.sender_ip;
        idx    = int'(it.slot_index);
        slots  = (it.packet_slots > UNIVERSE) ? CNT_W'(UNIVERSE) : it.packet_slots;
        wa     = 1'b0;
        wb     = 1'b0;
        acc    = 1'b0;
        hole   = 1'b0;
        case (it.operation)
            OP_DATA: begin
                if (ip != '0) begin
                    if (a_addr == '0) begin
                        a_addr = ip;
                        b_ext  = '0;
                    end
                    if (ip == a_addr) begin
                        a_cnt = slots;
                        m_cnt = (a_cnt > b_cnt) ? a_cnt : b_cnt;
                        wa    = (idx < slots);
                        a_ext = grow_extent(a_ext, idx, slots);
                        acc   = 1'b1;
                    end else begin
                        if (b_addr == '0) b_addr = ip;
                        if (ip == b_addr) begin
                            b_cnt = slots;
                            m_cnt = (a_cnt > b_cnt) ? a_cnt : b_cnt;
                            wb    = (idx < slots);
                            b_ext = grow_extent(b_ext, idx, slots);
                            acc   = 1'b1;
                        end
                    end
                end
            end
            OP_CANCEL: begin
                if (a_addr != ip) begin
                    a_addr = '0;
                    a_ext  = '0;
                end
                if (b_addr != ip) begin
                    b_addr = '0;
                    b_ext  = '0;
                end
            end
            OP_CLEAR: begin
                a_addr = '0;
                b_addr = '0;
                a_ext  = '0;
                b_ext  = '0;
                m_cnt  = CNT_W'(UNIVERSE);
            end
            default: begin
            end
        endcase
        la = '0;
        lb = '0;
        if (idx < a_ext) begin
            la = wa ? it.slot_value : levels_a[idx];
            if (!wa && !written_a[idx]) hole = 1'b1;
        end
        if (idx < b_ext) begin
            lb = wb ? it.slot_value : levels_b[idx];
            if (!wb && !written_b[idx]) hole = 1'b1;
        end
        res.out_index    = it.slot_index;
        res.merged_value = (la > lb) ? la : lb;
        res.merged_slots = m_cnt;
        res.accepted     = acc;
        if (commit) begin
            src_a_addr = a_addr;
            src_b_addr = b_addr;
            src_a_cnt  = a_cnt;
            src_b_cnt  = b_cnt;
            src_a_ext  = a_ext;
            src_b_ext  = b_ext;
            merged_cnt = m_cnt;
            if (wa) begin
                levels_a[idx]  = it.slot_value;
                written_a[idx] = 1'b1;
            end
            if (wb) begin
                levels_b[idx]  = it.slot_value;
                written_b[idx] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic void offer(input t_op op, input logic [IP_W-1:0] ip, input int slots,
                                  input int idx, input int val);
        t_pend p;
        bit    hole;
        p.hold              = 1'b0;
        p.item.operation    = op;
        p.item.sender_ip    = ip;
        p.item.packet_slots = CNT_W'(slots);
        p.item.slot_index   = IDX_W'(idx);
        p.item.slot_value   = LVL_W'(val);
        p.want = htp_predict(p.item, 1'b0, hole);
        // drop anything whose result would expose a level never written
        if (!hole) begin
            p.want = htp_predict(p.item, 1'b1, hole);
            pend_q.push_back(p);
            n_items++;
        end
    endfunction

    task automatic send_packet(input logic [IP_W-1:0] ip, input int declared, input int len);
        for (int i = 0; i < len; i++) begin
            // skip a slot now and then; the level from an earlier packet must survive
            if ($urandom_range(0, 9) != 0)
                offer(OP_DATA, ip, declared, i, $urandom_range(0, 255));
        end
    endtask

    function automatic void note_bad(input string msg);
        n_bad++;
        if (n_bad <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // Stimulus
    initial begin
        logic [IP_W-1:0] pool [3];
        t_pend           mark;
        int              pick, who, len, decl, k, big_left, next_phase;

        src_a_addr = '0;
        src_b_addr = '0;
        src_a_cnt  = '0;
        src_b_cnt  = '0;
        src_a_ext  = '0;
        src_b_ext  = '0;
        merged_cnt = '0;
        for (int i = 0; i < UNIVERSE; i++) begin
            levels_a[i]  = '0;
            levels_b[i]  = '0;
            written_a[i] = 1'b0;
            written_b[i] = 1'b0;
        end
        mark      = '0;
        mark.hold = 1'b1;

        // Directed: zero sender, claims, beyond-count byte, saturation, rejection,
        // skipped slot, cancel by B so B takes over A, clear, and the index extremes.
        offer(OP_READ,   32'h0000_0000,    0,   0, 8'h00);
        offer(OP_DATA,   32'h0000_0000,    3,   0, 8'h5A);
        offer(OP_DATA,   32'hC0A8_0001,    3,   0, 8'hFF);
        offer(OP_DATA,   32'hC0A8_0001,    3,   1, 8'h00);
        offer(OP_DATA,   32'hC0A8_0001,    3,   2, 8'h80);
        offer(OP_DATA,   32'hC0A8_0001,    3,   5, 8'h11);
        offer(OP_DATA,   32'hFFFF_FFFF, 1023,   0, 8'h10);
        offer(OP_DATA,   32'hFFFF_FFFF, 1023,   1, 8'h40);
        offer(OP_DATA,   32'h0A00_0001,    4,   0, 8'hEE);
        offer(OP_DATA,   32'hC0A8_0001,    3,   0, 8'h01);
        offer(OP_DATA,   32'hC0A8_0001,    3,   2, 8'h02);
        offer(OP_READ,   32'h0000_0000,    0,   1, 8'h00);
        offer(OP_READ,   32'hFFFF_FFFF, 1023, 511, 8'hFF);
        offer(OP_CANCEL, 32'hFFFF_FFFF,    0,   0, 8'h00);
        offer(OP_DATA,   32'hFFFF_FFFF,    2,   0, 8'h05);
        offer(OP_READ,   32'h0000_0000,    0,   0, 8'h00);
        offer(OP_DATA,   32'hFFFF_FFFF,    2,   1, 8'h06);
        offer(OP_CLEAR,  32'hC0A8_0001,  512,   0, 8'h00);
        offer(OP_READ,   32'h0000_0000,    0,   0, 8'h00);
        offer(OP_DATA,   32'h0A00_0001,  512, 511, 8'hAB);
        offer(OP_CANCEL, 32'h0000_0000,    0,   0, 8'h00);
        offer(OP_DATA,   32'h0A00_0001,    0,   0, 8'h77);
        pend_q.push_back(mark);

        big_left   = 2;
        next_phase = n_items;
        while (n_items < TOTAL_ITEMS) begin
            if (n_items >= next_phase) begin
                // new sender set; let the pipe drain first
                pend_q.push_back(mark);
                next_phase += PHASE_ITEMS;
                for (int j = 0; j < 3; j++) begin
                    pool[j] = $urandom;
                    if (pool[j] == '0) pool[j] = 32'h1;
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                who = $urandom_range(0, 9);
                if (who < 5) who = 0;
                else if (who < 9) who = 1;
                else who = 2;
                if (big_left > 0 && $urandom_range(0, 49) == 0) begin
                    len = UNIVERSE;
                    big_left--;
                end else begin
                    len = $urandom_range(1, 24);
                end
                k = $urandom_range(0, 99);
                if (k < 70) decl = len;
                else if (k < 85) decl = $urandom_range(0, len);
                else decl = $urandom_range(len, 1023);
                send_packet(pool[who], decl, len);
            end else if (pick < 75) begin
                if ($urandom_range(0, 4) != 0) k = $urandom_range(0, 31);
                else k = $urandom_range(0, UNIVERSE - 1);
                offer(OP_READ, $urandom, $urandom_range(0, 1023), k, $urandom_range(0, 255));
            end else if (pick < 85) begin
                offer(t_op'($urandom_range(0, 3)), $urandom, $urandom_range(0, 1023),
                      $urandom_range(0, UNIVERSE - 1), $urandom_range(0, 255));
            end else if (pick < 92) begin
                who = $urandom_range(0, 3);
                offer(OP_CANCEL, (who < 3) ? pool[who] : $urandom, $urandom_range(0, 1023),
                      $urandom_range(0, 31), $urandom_range(0, 255));
            end else if (pick < 96) begin
                offer(OP_CLEAR, $urandom, $urandom_range(0, 1023),
                      $urandom_range(0, 31), $urandom_range(0, 255));
            end else begin
                // zero sender and strangers
                for (int j = $urandom_range(1, 4); j > 0; j--)
                    offer(OP_DATA, ($urandom_range(0, 1) != 0) ? '0 : $urandom,
                          $urandom_range(0, 1023), $urandom_range(0, 31),
                          $urandom_range(0, 255));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || i_in_valid || merge_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_bad == 0 && merge_expect_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Driver: bursts with gaps; a hold mark waits for every result to come back
    always @(posedge i_clk) begin
        t_pend nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pend_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (pend_q[0].hold) begin
                i_in_valid <= 1'b0;
                if (!i_in_valid && merge_expect_q.size() == 0) void'(pend_q.pop_front());
            end else begin
                nxt = pend_q.pop_front();
                i_in_data  <= nxt.item;
                cur_want   <= nxt.want;
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    if ($urandom_range(0, 4) == 0) begin
                        burst_left <= $urandom_range(100, 300);
                        gap_left   <= 0;
                    end else begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= $urandom_range(0, 5);
                    end
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: picks a new stall pattern at random whenever the low seven bits of rx_cycle are zero
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 8'd1;
        if (rx_cycle[6:0] == 7'd0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN: i_out_ready <= 1'b1;
            RX_COIN: i_out_ready <= ($urandom_range(0, 1) != 0);
            RX_SLOW: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= rx_cycle[2];
        endcase
    end

    // Monitor: check each result transfer, record each input transfer, watch for a hang
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (merge_expect_q.size() == 0) begin
                    note_bad($sformatf("unexpected result: idx %0d value %0d slots %0d acc %0d",
                                       o_out_data.out_index, o_out_data.merged_value,
                                       o_out_data.merged_slots, o_out_data.accepted));
                end else begin
                    want = merge_expect_q.pop_front();
                    if (o_out_data !== want)
                        note_bad($sformatf({"mismatch: expected idx %0d value %0d slots %0d ",
                                            "acc %0d, got idx %0d value %0d slots %0d acc %0d"},
                                           want.out_index, want.merged_value,
                                           want.merged_slots, want.accepted,
                                           o_out_data.out_index, o_out_data.merged_value,
                                           o_out_data.merged_slots, o_out_data.accepted));
                end
            end
            if (i_in_valid && o_in_ready) merge_expect_q.push_back(cur_want);
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

`default_nettype wire

/* dmx_two_source_htp_merge_core.f */
design/dthm_pkg.sv
design/dthm_level_ram.sv
design/dthm_source_ctrl.sv
design/dthm_merge_out.sv
design/dmx_two_source_htp_merge_core.sv
sim/dmx_two_source_htp_merge_core_tb.sv
